// File: rtl/core/odo_pkg.sv
// Package for the path-length odometer: widths, request and result codes,
// register indexes, state types and the saturating add.
// No dependencies; every other file of the block imports it.
package odo_pkg;

  localparam int POS_WIDTH       = 24;
  localparam int TOTAL_WIDTH     = 48;
  localparam int MAG_WIDTH       = POS_WIDTH;
  localparam int LEG_WIDTH       = MAG_WIDTH + 1;
  localparam int RAD_WIDTH       = 2 * LEG_WIDTH;
  localparam int REM_WIDTH       = LEG_WIDTH + 2;
  localparam int CNT_WIDTH       = $clog2(LEG_WIDTH);
  localparam int THR_WIDTH       = POS_WIDTH - 1;
  localparam int TICK_WIDTH      = 16;
  localparam int CFG_DATA_WIDTH  = (THR_WIDTH > TICK_WIDTH) ? THR_WIDTH : TICK_WIDTH;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [1:0] REQ_X     = 2'd0;
  localparam logic [1:0] REQ_Y     = 2'd1;
  localparam logic [1:0] REQ_DEPTH = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic KIND_LEG    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEPTH_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NAV_TIMEOUT     = 1'b1;

  localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = 16'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LEG,
    ST_ACCUM,
    ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_MUL,
    LS_SUM,
    LS_ROOT,
    LS_DONE
  } leg_state_t;

  function automatic logic [TOTAL_WIDTH-1:0] sat_add(input logic [TOTAL_WIDTH-1:0] a,
                                                     input logic [LEG_WIDTH-1:0] b);
    logic [TOTAL_WIDTH:0] s;
    s = {1'b0, a} + (TOTAL_WIDTH + 1)'(b);
    return s[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : s[TOTAL_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/core/odo_if.sv
// Handshake interfaces for the odometer's request and result channels.
// Depends on odo_pkg for the payload widths.
interface odo_req_if;
  import odo_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic signed [POS_WIDTH-1:0] value;
  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

interface odo_res_if;
  import odo_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic [LEG_WIDTH-1:0]   leg_length;
  logic [TOTAL_WIDTH-1:0] total_distance;
  logic [TOTAL_WIDTH-1:0] depth_distance;
  logic                   stale_raised;
  logic                   nav_stale;
  modport source (output valid, output result_kind, output leg_length,
                  output total_distance, output depth_distance,
                  output stale_raised, output nav_stale, input ready);
  modport sink (input valid, input result_kind, input leg_length,
                input total_distance, input depth_distance,
                input stale_raised, input nav_stale, output ready);
endinterface

// File: rtl/core/odo_leg_unit.sv
// Leg length unit: two bit-serial squarers followed by a two-bits-per-step
// integer square root of the sum of squares. Depends on odo_pkg.
module odo_leg_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [odo_pkg::MAG_WIDTH-1:0] ax,
  input  logic [odo_pkg::MAG_WIDTH-1:0] ay,
  output logic                          done,
  output logic [odo_pkg::LEG_WIDTH-1:0] leg
);
  import odo_pkg::*;

  leg_state_t state, state_next;

  logic [CNT_WIDTH-1:0] cnt;
  logic [MAG_WIDTH-1:0] mcx, mcy;
  logic [MAG_WIDTH-1:0] hx, lx, hy, ly;
  logic [RAD_WIDTH-1:0] rad;
  logic [REM_WIDTH-1:0] rem;
  logic [LEG_WIDTH-1:0] root;

  logic [MAG_WIDTH:0]   sum_x, sum_y;
  logic [REM_WIDTH-1:0] rem_sh, trial;
  logic                 last;

  assign sum_x  = {1'b0, hx} + (lx[0] ? {1'b0, mcx} : '0);
  assign sum_y  = {1'b0, hy} + (ly[0] ? {1'b0, mcy} : '0);
  assign rem_sh = {rem[REM_WIDTH-3:0], rad[RAD_WIDTH-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign last   = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      LS_IDLE: if (start) state_next = LS_MUL;
      LS_MUL:  if (last) state_next = LS_SUM;
      LS_SUM:  state_next = LS_ROOT;
      LS_ROOT: if (last) state_next = LS_DONE;
      LS_DONE: state_next = LS_IDLE;
      default: state_next = LS_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    case (state)
      LS_DONE: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      LS_IDLE: begin
        mcx <= ax;
        mcy <= ay;
        lx  <= ax;
        ly  <= ay;
        hx  <= '0;
        hy  <= '0;
        cnt <= CNT_WIDTH'(MAG_WIDTH - 1);
      end
      LS_MUL: begin
        hx  <= sum_x[MAG_WIDTH:1];
        lx  <= {sum_x[0], lx[MAG_WIDTH-1:1]};
        hy  <= sum_y[MAG_WIDTH:1];
        ly  <= {sum_y[0], ly[MAG_WIDTH-1:1]};
        cnt <= cnt - 1'b1;
      end
      LS_SUM: begin
        rad  <= RAD_WIDTH'({hx, lx}) + RAD_WIDTH'({hy, ly});
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_WIDTH'(LEG_WIDTH - 1);
      end
      LS_ROOT: begin
        rad <= {rad[RAD_WIDTH-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[LEG_WIDTH-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[LEG_WIDTH-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign leg = root;

endmodule

// File: rtl/core/odometry_distance_accumulator_core.sv
// Euclidean path-length odometer. An X or Y request after the first fix
// yields a leg result, computed by the bit-serial squarers and the 25-step
// square root; a tick yields a report, and depth updates and the first fix
// produce no result. One request is worked at a time, and a finished result
// may wait in the output register while the next request is taken.
// Configuration must be written only while the block is idle. Depends on
// odo_pkg, odo_if and odo_leg_unit.
module odometry_distance_accumulator_core (
  input  logic                                clk,
  input  logic                                rst,
  odo_req_if.sink                             req,
  odo_res_if.source                           res,
  input  logic                                wr_en,
  input  logic [odo_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [odo_pkg::CFG_DATA_WIDTH-1:0]  wr_data
);
  import odo_pkg::*;

  top_state_t state, state_next;

  logic [THR_WIDTH-1:0]   depth_threshold;
  logic [TICK_WIDTH-1:0]  nav_timeout;
  logic [POS_WIDTH-1:0]   x_cur, y_cur, x_prev, y_prev, depth_cur;
  logic                   awaiting_first;
  logic [TOTAL_WIDTH-1:0] sum_all, sum_deep;
  logic [TICK_WIDTH-1:0]  ticks;
  logic                   warned;
  logic                   kind;
  logic                   raise;
  logic                   out_valid;

  logic                   accept, leg_start, load_out, leg_done, is_tick, is_pos;
  logic [POS_WIDTH-1:0]   x_cur_next, y_cur_next;
  logic [TICK_WIDTH-1:0]  ticks_next;
  logic                   raise_next;
  logic [POS_WIDTH:0]     dx, dy;
  logic [POS_WIDTH:0]     mx, my;
  logic [LEG_WIDTH-1:0]   leg;
  logic                   deep;

  assign accept  = req.valid && req.ready;
  assign is_tick = (req.req_type == REQ_TICK);
  assign is_pos  = (req.req_type == REQ_X) || (req.req_type == REQ_Y);

  assign x_cur_next = (req.req_type == REQ_X) ? req.value : x_cur;
  assign y_cur_next = (req.req_type == REQ_Y) ? req.value : y_cur;
  assign ticks_next = (ticks == {TICK_WIDTH{1'b1}}) ? ticks : ticks + 1'b1;
  assign raise_next = !awaiting_first && (ticks_next >= nav_timeout) && !warned;

  assign dx   = {x_cur[POS_WIDTH-1], x_cur} - {x_prev[POS_WIDTH-1], x_prev};
  assign dy   = {y_cur[POS_WIDTH-1], y_cur} - {y_prev[POS_WIDTH-1], y_prev};
  assign mx   = dx[POS_WIDTH] ? -dx : dx;
  assign my   = dy[POS_WIDTH] ? -dy : dy;
  assign deep = $signed(depth_cur) > $signed({1'b0, depth_threshold});

  odo_leg_unit u_leg (
    .clk   (clk),
    .rst   (rst),
    .start (leg_start),
    .ax    (mx[MAG_WIDTH-1:0]),
    .ay    (my[MAG_WIDTH-1:0]),
    .done  (leg_done),
    .leg   (leg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_tick) begin
          state_next = ST_EMIT;
        end else if (accept && is_pos && !awaiting_first) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_LEG;
      ST_LEG:   if (leg_done) state_next = ST_ACCUM;
      ST_ACCUM: state_next = ST_EMIT;
      ST_EMIT:  if (!out_valid || res.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    leg_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:  req.ready = 1'b1;
      ST_START: leg_start = 1'b1;
      ST_EMIT:  load_out = !out_valid || res.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_threshold <= '0;
      nav_timeout     <= TIMEOUT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEPTH_THRESHOLD: depth_threshold <= wr_data[THR_WIDTH-1:0];
        REG_NAV_TIMEOUT:     nav_timeout <= wr_data[TICK_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cur          <= '0;
      y_cur          <= '0;
      x_prev         <= '0;
      y_prev         <= '0;
      depth_cur      <= '0;
      awaiting_first <= 1'b1;
      sum_all        <= '0;
      sum_deep       <= '0;
      ticks          <= '0;
      warned         <= 1'b0;
    end else begin
      if (accept) begin
        if (req.req_type == REQ_DEPTH) begin
          depth_cur <= req.value;
        end else if (is_tick) begin
          ticks <= ticks_next;
          if (raise_next) begin
            warned <= 1'b1;
          end
        end else begin
          x_cur  <= x_cur_next;
          y_cur  <= y_cur_next;
          ticks  <= '0;
          warned <= 1'b0;
          if (awaiting_first) begin
            x_prev         <= x_cur_next;
            y_prev         <= y_cur_next;
            awaiting_first <= 1'b0;
          end
        end
      end
      if (state == ST_ACCUM) begin
        sum_all <= sat_add(sum_all, leg);
        if (deep) begin
          sum_deep <= sat_add(sum_deep, leg);
        end
        x_prev <= x_cur;
        y_prev <= y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= is_tick ? KIND_REPORT : KIND_LEG;
      raise <= is_tick && raise_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.result_kind    <= kind;
      res.leg_length     <= (kind == KIND_REPORT) ? '0 : leg;
      res.total_distance <= sum_all;
      res.depth_distance <= sum_deep;
      res.stale_raised   <= raise;
      res.nav_stale      <= (kind == KIND_REPORT) ? warned : 1'b0;
    end
  end

  assign res.valid = out_valid;

endmodule
